// File: sv/go_back_n_link_controller_top_defines.svh
// ---------------------------------------------------------------------------
// go-back-n link controller assertion macros
// concurrent checks on clk, disabled or kept through reset
// ---------------------------------------------------------------------------
`ifndef GO_BACK_N_LINK_CONTROLLER_TOP_DEFINES_SVH
`define GO_BACK_N_LINK_CONTROLLER_TOP_DEFINES_SVH

`ifndef SYNTHESIS

// check that is disabled while reset is asserted
`define GBNLC_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// check that also holds during reset
`define GBNLC_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define GBNLC_ASSERT(lbl, prop, msg)
`define GBNLC_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

// File: sv/gbnlc_pkg.sv
// ---------------------------------------------------------------------------
// gbnlc_pkg
// types and codes of the go-back-n link controller
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package gbnlc_pkg;

	localparam int SEQ_W    = 4;
	localparam int SEQ_MOD  = 16;
	localparam int TAG_BITS = 32;

	// largest number of outstanding frames
	localparam logic [SEQ_W-1:0] SEQ_MAX = 4'd15;

	typedef logic [SEQ_W-1:0]    seq_t;
	typedef logic [TAG_BITS-1:0] tag_t;

	// link event codes
	typedef enum logic [2:0] {
		REQ_NEW_PKT  = 3'd0,
		REQ_PHYS_RDY = 3'd1,
		REQ_FRAME    = 3'd2,
		REQ_DATA_TO  = 3'd3,
		REQ_ACK_TO   = 3'd4
	} req_t;

	// result action codes
	typedef enum logic [2:0] {
		ACT_STATUS  = 3'd0,
		ACT_SEND    = 3'd1,
		ACT_ACK     = 3'd2,
		ACT_DELIVER = 3'd3,
		ACT_STOP    = 3'd4
	} act_t;

	// sequencer states
	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_HEAD = 3'b010,
		ST_RUN  = 3'b100
	} state_t;

endpackage

// File: sv/go_back_n_link_controller_top.sv
// ---------------------------------------------------------------------------
// go_back_n_link_controller_top
// go-back-n sender and receiver control with a descriptor store
// ---------------------------------------------------------------------------
// One link event is taken per item. The window edges, outstanding count and
// physical-ready flag are updated in the cycle the item is accepted; the
// results are then played out of a small sequencer, one per cycle while the
// output side takes them. An item gives n results (n is 1 to 16): at most
// one leading result (send, deliver, ack or status) and a run of timer stops
// or resends. Resent descriptors come from a 16-entry store with a registered
// read; the first read is issued at acceptance, so the run still moves one
// result per cycle while the output side takes them. A new item is accepted
// once the last result of the previous one is in the output register.
`timescale 1ns / 1ps

`include "go_back_n_link_controller_top_defines.svh"

module go_back_n_link_controller_top
	import gbnlc_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [2:0]          req_type,
	input  logic [TAG_BITS-1:0] tx_packet_tag,
	input  logic                rx_frame_ok,
	input  logic                rx_kind,
	input  logic [SEQ_W-1:0]    rx_seq,
	input  logic [SEQ_W-1:0]    rx_ack,
	input  logic [TAG_BITS-1:0] rx_packet_tag,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [2:0]          action,
	output logic [SEQ_W-1:0]    frame_seq,
	output logic [SEQ_W-1:0]    ack_num,
	output logic [TAG_BITS-1:0] packet_tag,
	output logic                net_enable,
	output logic                last
);

	// link state
	seq_t   window_low_q, next_seq_q, rx_expected_q, outstanding_q;
	logic   phys_ready_q;
	state_t state_q;

	// per-item sequencer registers
	act_t   head_act_q;
	seq_t   head_seq_q, head_ack_q;
	tag_t   head_tag_q;
	seq_t   run_cnt_q, run_seq_q;
	logic   run_resend_q;
	logic   en_q;

	// output register
	logic   out_valid_q;
	act_t   out_act_q;
	seq_t   out_seq_q, out_ack_q;
	tag_t   out_tag_q;
	logic   out_en_q, out_last_q;

	// descriptor store
	tag_t   mem_q [SEQ_MOD];
	tag_t   rd_data_q;
	logic   rd_en, wr_en;
	seq_t   rd_addr;

	// accept-time next values
	seq_t   wl_d, ns_d, rx_d, os_d, ack_dist, piggy;
	logic   pr_d, en_d, hd_v;
	act_t   hd_act;
	seq_t   hd_seq, hd_ack;
	tag_t   hd_tag;
	seq_t   rn_cnt;
	logic   rn_resend;

	logic   in_fire, slot_free, emit, run_more_read;
	act_t   em_act;
	seq_t   em_seq, em_ack;
	tag_t   em_tag;
	logic   em_last;

	assign in_ready  = (state_q == ST_IDLE);
	assign in_fire   = in_valid && in_ready;
	assign slot_free = !out_valid_q || out_ready;
	assign emit      = slot_free && (state_q != ST_IDLE);
	assign piggy     = rx_expected_q - seq_t'(1);
	assign ack_dist  = rx_ack - window_low_q;

	// event decode and state update at acceptance
	always_comb begin
		wl_d      = window_low_q;
		ns_d      = next_seq_q;
		rx_d      = rx_expected_q;
		os_d      = outstanding_q;
		pr_d      = phys_ready_q;
		hd_v      = 1'b0;
		hd_act    = ACT_STATUS;
		hd_seq    = '0;
		hd_ack    = '0;
		hd_tag    = '0;
		rn_cnt    = '0;
		rn_resend = 1'b0;
		wr_en     = 1'b0;
		unique case (req_type)
			REQ_NEW_PKT: begin
				if (outstanding_q < SEQ_MAX) begin
					os_d   = outstanding_q + seq_t'(1);
					pr_d   = 1'b0;
					ns_d   = next_seq_q + seq_t'(1);
					wr_en  = in_fire;
					hd_v   = 1'b1;
					hd_act = ACT_SEND;
					hd_seq = next_seq_q;
					hd_ack = piggy;
					hd_tag = tx_packet_tag;
				end
			end
			REQ_PHYS_RDY: begin
				pr_d = 1'b1;
			end
			REQ_FRAME: begin
				if (rx_frame_ok) begin
					if (!rx_kind && (rx_seq == rx_expected_q)) begin
						hd_v   = 1'b1;
						hd_act = ACT_DELIVER;
						hd_seq = rx_seq;
						hd_tag = rx_packet_tag;
						rx_d   = rx_expected_q + seq_t'(1);
					end
					// cumulative ack inside the window
					if (ack_dist < outstanding_q) begin
						rn_cnt = ack_dist + seq_t'(1);
						os_d   = outstanding_q - (ack_dist + seq_t'(1));
						wl_d   = rx_ack + seq_t'(1);
					end
				end
			end
			REQ_DATA_TO: begin
				ns_d      = window_low_q + outstanding_q;
				rn_cnt    = outstanding_q;
				rn_resend = 1'b1;
				if (outstanding_q != '0) begin
					pr_d = 1'b0;
				end
			end
			REQ_ACK_TO: begin
				pr_d   = 1'b0;
				hd_v   = 1'b1;
				hd_act = ACT_ACK;
				hd_ack = piggy;
			end
			default: begin
			end
		endcase
		// nothing else to report gives a status result
		if (!hd_v && (rn_cnt == '0)) begin
			hd_v = 1'b1;
		end
		en_d = (os_d < SEQ_MAX) && pr_d;
	end

	// store read port: first resend at acceptance, then one ahead of the run
	assign run_more_read = emit && (state_q == ST_RUN) && run_resend_q &&
		(run_cnt_q != seq_t'(1));
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = window_low_q;
		if (in_fire && rn_resend && (rn_cnt != '0)) begin
			rd_en   = 1'b1;
			rd_addr = window_low_q;
		end else if (run_more_read) begin
			rd_en   = 1'b1;
			rd_addr = run_seq_q + seq_t'(1);
		end
	end

	// descriptor store, one write and one registered read
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[next_seq_q] <= tx_packet_tag;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	// result selection
	always_comb begin
		if (state_q == ST_HEAD) begin
			em_act  = head_act_q;
			em_seq  = head_seq_q;
			em_ack  = head_ack_q;
			em_tag  = head_tag_q;
			em_last = (run_cnt_q == '0);
		end else begin
			em_act  = run_resend_q ? ACT_SEND : ACT_STOP;
			em_seq  = run_seq_q;
			em_ack  = run_resend_q ? piggy : seq_t'(0);
			em_tag  = run_resend_q ? rd_data_q : tag_t'(0);
			em_last = (run_cnt_q == seq_t'(1));
		end
	end

	// link state and sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_low_q  <= '0;
			next_seq_q    <= '0;
			rx_expected_q <= '0;
			outstanding_q <= '0;
			phys_ready_q  <= 1'b0;
			state_q       <= ST_IDLE;
			run_cnt_q     <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						window_low_q  <= wl_d;
						next_seq_q    <= ns_d;
						rx_expected_q <= rx_d;
						outstanding_q <= os_d;
						phys_ready_q  <= pr_d;
						run_cnt_q     <= rn_cnt;
						state_q       <= hd_v ? ST_HEAD : ST_RUN;
					end
				end
				ST_HEAD: begin
					if (emit) begin
						state_q <= (run_cnt_q != '0) ? ST_RUN : ST_IDLE;
					end
				end
				ST_RUN: begin
					if (emit) begin
						run_cnt_q <= run_cnt_q - seq_t'(1);
						if (run_cnt_q == seq_t'(1)) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// per-item payload registers
	always_ff @(posedge clk) begin
		if (in_fire) begin
			head_act_q   <= hd_act;
			head_seq_q   <= hd_seq;
			head_ack_q   <= hd_ack;
			head_tag_q   <= hd_tag;
			run_seq_q    <= window_low_q;
			run_resend_q <= rn_resend;
			en_q         <= en_d;
		end else if (emit && (state_q == ST_RUN)) begin
			run_seq_q <= run_seq_q + seq_t'(1);
		end
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (emit) begin
			out_act_q  <= em_act;
			out_seq_q  <= em_seq;
			out_ack_q  <= em_ack;
			out_tag_q  <= em_tag;
			out_en_q   <= en_q;
			out_last_q <= em_last;
		end
	end

	assign out_valid  = out_valid_q;
	assign action     = out_act_q;
	assign frame_seq  = out_seq_q;
	assign ack_num    = out_ack_q;
	assign packet_tag = out_tag_q;
	assign net_enable = out_en_q;
	assign last       = out_last_q;

	// checks
	`GBNLC_ASSERT(a_fire_leaves_idle, in_fire |=> (state_q != ST_IDLE), "item accepted but sequencer stayed idle")
	`GBNLC_ASSERT_ALWAYS(a_idle_no_run, (state_q == ST_IDLE) |-> (run_cnt_q == '0), "run count left over in idle")
	`GBNLC_ASSERT(a_run_nonzero, (state_q == ST_RUN) |-> (run_cnt_q != '0), "run state with nothing to emit")
	`GBNLC_ASSERT(a_last_ends_item, (emit && em_last) |=> (state_q == ST_IDLE), "last result emitted but item not closed")

endmodule

// File: verif/testbench.sv
// ---------------------------------------------------------------------------
// go-back-n link controller testbench
// drives link events through valid/ready, predicts every result with an
// in-bench copy of the window, receiver and descriptor state, and checks the
// results in order under several idle and stall mixes
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
	import gbnlc_pkg::*;

	localparam int CLK_HALF    = 2;
	localparam int CYCLE_LIMIT = 500000;
	localparam int HOLD_CYCLES = 400;
	localparam int DRAIN_WAIT  = 40;
	localparam int RAND_ITEMS  = 55;
	localparam int BURST_ITEMS = 20;

	// request codes the block ignores
	localparam logic [2:0] REQ_UNUSED_LO = 3'd5;
	localparam logic [2:0] REQ_UNUSED_HI = 3'd7;

	typedef struct packed {
		logic [2:0] req;
		tag_t       tx_tag;
		logic       ok;
		logic       kind;
		seq_t       seq;
		seq_t       ack;
		tag_t       rx_tag;
	} link_event_t;

	typedef struct packed {
		act_t act;
		seq_t seq;
		seq_t ack;
		tag_t tag;
		logic en;
		logic is_last;
	} link_result_t;

	typedef struct {
		link_event_t  ev;
		int           reps;
		bit           typed;
		link_result_t res;
	} stim_row_t;

	// dut ports
	logic                clk           = 1'b0;
	logic                arst_n        = 1'b1;
	logic                in_valid      = 1'b0;
	logic                in_ready;
	logic [2:0]          req_type      = '0;
	logic [TAG_BITS-1:0] tx_packet_tag = '0;
	logic                rx_frame_ok   = 1'b0;
	logic                rx_kind       = 1'b0;
	logic [SEQ_W-1:0]    rx_seq        = '0;
	logic [SEQ_W-1:0]    rx_ack        = '0;
	logic [TAG_BITS-1:0] rx_packet_tag = '0;
	logic                out_valid;
	logic                out_ready     = 1'b0;
	logic [2:0]          action;
	logic [SEQ_W-1:0]    frame_seq;
	logic [SEQ_W-1:0]    ack_num;
	logic [TAG_BITS-1:0] packet_tag;
	logic                net_enable;
	logic                last;

	// predicted link state
	seq_t window_low;
	seq_t next_seq;
	seq_t rx_expected;
	seq_t outstanding;
	logic phys_ready;
	tag_t tag_store [SEQ_MOD];

	link_result_t event_results[$];
	link_result_t awaited_results[$];
	link_result_t front_result;
	stim_row_t    stim_table[$];

	int mismatch_count = 0;
	int cycle_count    = 0;
	int send_idle_pct  = 0;
	int recv_stall_pct = 0;
	int hold_requests  = 0;
	int hold_served    = 0;
	int hold_left      = 0;

	go_back_n_link_controller_top uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.req_type      (req_type),
		.tx_packet_tag (tx_packet_tag),
		.rx_frame_ok   (rx_frame_ok),
		.rx_kind       (rx_kind),
		.rx_seq        (rx_seq),
		.rx_ack        (rx_ack),
		.rx_packet_tag (rx_packet_tag),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.action        (action),
		.frame_seq     (frame_seq),
		.ack_num       (ack_num),
		.packet_tag    (packet_tag),
		.net_enable    (net_enable),
		.last          (last)
	);

	always #(CLK_HALF) clk = ~clk;

	// one line per mismatch
	task automatic flag_mismatch(input string msg);
		$display("[%0t] mismatch: %s", $time, msg);
		mismatch_count++;
	endtask

	function automatic void note_result(act_t a, seq_t s, seq_t k, tag_t t);
		link_result_t r;
		r.act     = a;
		r.seq     = s;
		r.ack     = k;
		r.tag     = t;
		r.en      = 1'b0;
		r.is_last = 1'b0;
		event_results.push_back(r);
	endfunction

	// data frame send, clears the physical-ready flag
	function automatic void transmit(seq_t s);
		phys_ready = 1'b0;
		note_result(ACT_SEND, s, rx_expected - 4'd1, tag_store[s]);
	endfunction

	// predicted results of one accepted link event
	function automatic void advance_link(link_event_t ev);
		seq_t ack_gap;
		int   cnt;
		logic en;
		event_results.delete();
		case (ev.req)
			REQ_NEW_PKT: begin
				if (outstanding < SEQ_MAX) begin
					outstanding++;
					tag_store[next_seq] = ev.tx_tag;
					transmit(next_seq);
					next_seq++;
				end
			end
			REQ_PHYS_RDY: phys_ready = 1'b1;
			REQ_FRAME: begin
				if (ev.ok) begin
					// in-order data is delivered before the ack is handled
					if (!ev.kind && ev.seq == rx_expected) begin
						note_result(ACT_DELIVER, ev.seq, '0, ev.rx_tag);
						rx_expected++;
					end
					// cumulative ack slides the window past rx_ack
					ack_gap = ev.ack - window_low;
					if (ack_gap < outstanding) begin
						for (cnt = 0; cnt <= int'(ack_gap); cnt++) begin
							note_result(ACT_STOP, window_low, '0, '0);
							outstanding--;
							window_low++;
						end
					end
				end
			end
			REQ_DATA_TO: begin
				// go back and resend everything outstanding
				next_seq = window_low;
				for (cnt = 0; cnt < int'(outstanding); cnt++) begin
					transmit(next_seq);
					next_seq++;
				end
			end
			REQ_ACK_TO: begin
				phys_ready = 1'b0;
				note_result(ACT_ACK, '0, rx_expected - 4'd1, '0);
			end
			default: ;
		endcase
		if (event_results.size() == 0)
			note_result(ACT_STATUS, '0, '0, '0);
		en = (outstanding < SEQ_MAX) && phys_ready;
		foreach (event_results[i])
			event_results[i].en = en;
		event_results[event_results.size() - 1].is_last = 1'b1;
	endfunction

	function automatic tag_t pick_tag();
		case ($urandom_range(0, 9))
			0:       return '0;
			1:       return '1;
			default: return tag_t'($urandom);
		endcase
	endfunction

	// mostly well-formed traffic shaped by the current window
	function automatic link_event_t random_event();
		link_event_t ev;
		int          pick;
		ev.tx_tag = pick_tag();
		ev.rx_tag = pick_tag();
		ev.ok     = ($urandom_range(0, 9) != 0);
		ev.kind   = 1'($urandom_range(0, 1));
		ev.seq    = ($urandom_range(0, 3) != 0) ? rx_expected : seq_t'($urandom_range(0, 15));
		if (outstanding != 0 && $urandom_range(0, 3) != 0)
			ev.ack = seq_t'(window_low + $urandom_range(0, outstanding - 1));
		else
			ev.ack = seq_t'($urandom_range(0, 15));
		pick = $urandom_range(0, 99);
		if (pick < 35)
			ev.req = REQ_NEW_PKT;
		else if (pick < 45)
			ev.req = REQ_PHYS_RDY;
		else if (pick < 80)
			ev.req = REQ_FRAME;
		else if (pick < 88)
			ev.req = REQ_DATA_TO;
		else if (pick < 95)
			ev.req = REQ_ACK_TO;
		else
			ev.req = 3'($urandom_range(REQ_UNUSED_LO, REQ_UNUSED_HI));
		return ev;
	endfunction

	function automatic stim_row_t mk_row(logic [2:0] req, tag_t txt, logic ok, logic kind,
			seq_t sq, seq_t ak, tag_t rxt, int reps, bit typed,
			act_t a, seq_t rs, seq_t ra, tag_t rt, logic ren);
		stim_row_t row;
		row.ev          = '{req, txt, ok, kind, sq, ak, rxt};
		row.reps        = reps;
		row.typed       = typed;
		row.res.act     = a;
		row.res.seq     = rs;
		row.res.ack     = ra;
		row.res.tag     = rt;
		row.res.en      = ren;
		row.res.is_last = 1'b1;
		return row;
	endfunction

	// offer one item, hold it until accepted, then queue its results
	task automatic offer(input link_event_t ev, input bit typed, input link_result_t res);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid      <= 1'b1;
		req_type      <= ev.req;
		tx_packet_tag <= ev.tx_tag;
		rx_frame_ok   <= ev.ok;
		rx_kind       <= ev.kind;
		rx_seq        <= ev.seq;
		rx_ack        <= ev.ack;
		rx_packet_tag <= ev.rx_tag;
		do
			@(posedge clk);
		while (!in_ready);
		advance_link(ev);
		if (typed)
			awaited_results.push_back(res);
		else
			foreach (event_results[i])
				awaited_results.push_back(event_results[i]);
	endtask

	task automatic wait_drained();
		while (awaited_results.size() != 0)
			@(posedge clk);
	endtask

	// output side: random stalls plus long hold-offs on request
	always @(posedge clk) begin
		if (hold_served != hold_requests) begin
			hold_served <= hold_served + 1;
			hold_left   <= HOLD_CYCLES;
			out_ready   <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
		end
	end

	// result checker
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (awaited_results.size() == 0) begin
				flag_mismatch($sformatf("unexpected result action %0d seq %0d",
					action, frame_seq));
			end else begin
				front_result = awaited_results.pop_front();
				if (action !== front_result.act)
					flag_mismatch($sformatf("action %0d want %0d", action, front_result.act));
				if (frame_seq !== front_result.seq)
					flag_mismatch($sformatf("frame_seq %0d want %0d", frame_seq,
						front_result.seq));
				if (ack_num !== front_result.ack)
					flag_mismatch($sformatf("ack_num %0d want %0d", ack_num,
						front_result.ack));
				if (packet_tag !== front_result.tag)
					flag_mismatch($sformatf("packet_tag %h want %h", packet_tag,
						front_result.tag));
				if (net_enable !== front_result.en)
					flag_mismatch($sformatf("net_enable %b want %b", net_enable,
						front_result.en));
				if (last !== front_result.is_last)
					flag_mismatch($sformatf("last %b want %b", last, front_result.is_last));
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	initial begin
		link_event_t  ev;
		link_result_t no_result;
		int           k;
		int           ph;

		no_result   = '0;
		window_low  = '0;
		next_seq    = '0;
		rx_expected = '0;
		outstanding = '0;
		phys_ready  = 1'b0;
		foreach (tag_store[i])
			tag_store[i] = '0;

		// directed items: status cases, extremes, full window, resend, cumulative acks
		stim_table.push_back(mk_row(REQ_PHYS_RDY, '0, 0, 0, 0, 0, '0, 1, 1,
			ACT_STATUS, 0, 0, '0, 1));
		stim_table.push_back(mk_row(REQ_ACK_TO, '0, 0, 0, 0, 0, '0, 1, 1,
			ACT_ACK, 0, 15, '0, 0));
		stim_table.push_back(mk_row(REQ_DATA_TO, '0, 0, 0, 0, 0, '0, 1, 1,
			ACT_STATUS, 0, 0, '0, 0));
		stim_table.push_back(mk_row(REQ_UNUSED_HI, '1, 1, 1, 15, 15, '1, 1, 1,
			ACT_STATUS, 0, 0, '0, 0));
		stim_table.push_back(mk_row(REQ_FRAME, '0, 0, 0, 0, 0, '1, 1, 1,
			ACT_STATUS, 0, 0, '0, 0));
		stim_table.push_back(mk_row(REQ_NEW_PKT, '1, 0, 0, 0, 0, '0, 1, 1,
			ACT_SEND, 0, 15, '1, 0));
		stim_table.push_back(mk_row(REQ_NEW_PKT, '0, 0, 0, 0, 0, '0, 1, 1,
			ACT_SEND, 1, 15, '0, 0));
		stim_table.push_back(mk_row(REQ_NEW_PKT, 32'h0000_0001, 0, 0, 0, 0, '0, 13, 0,
			ACT_STATUS, 0, 0, '0, 0));
		// window full: new packet ignored, phys ready cannot enable the network
		stim_table.push_back(mk_row(REQ_NEW_PKT, 32'hA5A5_A5A5, 0, 0, 0, 0, '0, 1, 1,
			ACT_STATUS, 0, 0, '0, 0));
		stim_table.push_back(mk_row(REQ_PHYS_RDY, '0, 0, 0, 0, 0, '0, 1, 1,
			ACT_STATUS, 0, 0, '0, 0));
		stim_table.push_back(mk_row(REQ_DATA_TO, '0, 0, 0, 0, 0, '0, 1, 0,
			ACT_STATUS, 0, 0, '0, 0));
		stim_table.push_back(mk_row(REQ_FRAME, '0, 1, 1, 0, 15, '0, 1, 0,
			ACT_STATUS, 0, 0, '0, 0));
		stim_table.push_back(mk_row(REQ_FRAME, '0, 1, 0, 3, 2, 32'h1234_5678, 1, 0,
			ACT_STATUS, 0, 0, '0, 0));
		stim_table.push_back(mk_row(REQ_FRAME, '0, 1, 0, 0, 14, '1, 1, 0,
			ACT_STATUS, 0, 0, '0, 0));
		stim_table.push_back(mk_row(REQ_PHYS_RDY, '0, 0, 0, 0, 0, '0, 1, 1,
			ACT_STATUS, 0, 0, '0, 1));
		stim_table.push_back(mk_row(REQ_ACK_TO, '0, 0, 0, 0, 0, '0, 1, 1,
			ACT_ACK, 0, 0, '0, 0));
		stim_table.push_back(mk_row(REQ_NEW_PKT, '0, 0, 0, 0, 0, '0, 1, 0,
			ACT_STATUS, 0, 0, '0, 0));
		stim_table.push_back(mk_row(REQ_FRAME, '0, 1, 0, 1, 15, '0, 1, 0,
			ACT_STATUS, 0, 0, '0, 0));
		stim_table.push_back(mk_row(REQ_UNUSED_LO, '0, 0, 0, 0, 0, '0, 1, 0,
			ACT_STATUS, 0, 0, '0, 0));

		// reset
		arst_n <= 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		foreach (stim_table[r]) begin
			for (k = 0; k < stim_table[r].reps; k++) begin
				ev        = stim_table[r].ev;
				ev.tx_tag = ev.tx_tag + k;
				offer(ev, stim_table[r].typed, stim_table[r].res);
			end
		end
		in_valid <= 1'b0;
		wait_drained();

		// random phases: no idling, sender idle, receiver stall, both
		for (ph = 0; ph < 4; ph++) begin
			send_idle_pct  = (ph == 1) ? 62 : (ph == 3) ? 14 : 0;
			recv_stall_pct = (ph == 2) ? 62 : (ph == 3) ? 14 : 0;
			for (k = 0; k < RAND_ITEMS; k++)
				offer(random_event(), 0, no_result);
			if (ph == 0) begin
				// long output hold-off while new packets keep coming
				hold_requests = hold_requests + 1;
				for (k = 0; k < BURST_ITEMS; k++) begin
					ev     = random_event();
					ev.req = REQ_NEW_PKT;
					offer(ev, 0, no_result);
				end
			end
			// sender pauses until every result is back
			in_valid <= 1'b0;
			wait_drained();
		end

		in_valid <= 1'b0;
		wait_drained();
		repeat (DRAIN_WAIT) @(posedge clk);
		if (mismatch_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

// File: go_back_n_link_controller_top.f
+incdir+sv
sv/gbnlc_pkg.sv
sv/go_back_n_link_controller_top.sv
verif/testbench.sv
